// ===== src/crt_pkg.sv =====
package crt_pkg;

    localparam int COORD_BITS_DEF = 24;
    localparam int QUEUE_DEPTH    = 2;

    typedef enum logic [1:0] {
        KIND_CIRC_CIRC = 2'd0,
        KIND_RECT_RECT = 2'd1,
        KIND_CIRC_RECT = 2'd2,
        KIND_RECT_CIRC = 2'd3
    } kind_t;

endpackage

// ===== src/circle_rect_collision_test_unit.sv =====
// channel | dir | tdata (low bit up)                                          | tuser
// s_      | in  | left_x, left_y, left_width, left_height, right_x, right_y,
//         |     | right_width, right_height, zero pad to bytes                | kind
// m_      | out | hit, zero pad to 8 bits                                     | -
//
// One word per cycle sustained while m_ is not stalled; from the accepting edge to m_tvalid
// a word passes the front register, the queue, offset stage, square stage and output register.
// The square stage holds the five multipliers and sets the clock.
// aresetn is synchronous and clears only valid flags, queue pointers and the queue count.
// A stall on m_ backs up the pipeline, then the two-word queue, then s_tready.
module circle_rect_collision_test_unit #(
    parameter int COORD_BITS = crt_pkg::COORD_BITS_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    // left_x, left_y, left_width, left_height, right_x, right_y, right_width, right_height
    input  logic [((8*COORD_BITS-4+7)/8)*8-1:0] s_tdata,
    // kind
    input  logic [1:0] s_tuser,
    output logic m_tvalid,
    input  logic m_tready,
    // hit
    output logic [7:0] m_tdata
);

    localparam int C     = COORD_BITS;
    localparam int JOB_W = 2*(C+2) + 3*C;

    logic job_valid, job_ready;
    logic signed [C+1:0] job_ex, job_ey;
    logic [C-1:0] job_d, job_w, job_h;
    logic q_valid, q_ready;
    logic [JOB_W-1:0] q_wdata, q_rdata;

    crt_front #(.COORD_BITS(COORD_BITS)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job_ex    (job_ex),
        .job_ey    (job_ey),
        .job_d     (job_d),
        .job_w     (job_w),
        .job_h     (job_h)
    );

    assign q_wdata = {job_ex, job_ey, job_d, job_w, job_h};

    crt_fifo #(.DATA_W(JOB_W)) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (job_valid),
        .wr_ready (job_ready),
        .wr_data  (q_wdata),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_data  (q_rdata)
    );

    crt_back #(.COORD_BITS(COORD_BITS)) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (q_valid),
        .job_ready (q_ready),
        .job_ex    ($signed(q_rdata[JOB_W-1 -: C+2])),
        .job_ey    ($signed(q_rdata[JOB_W-C-3 -: C+2])),
        .job_d     (q_rdata[3*C-1:2*C]),
        .job_w     (q_rdata[2*C-1:C]),
        .job_h     (q_rdata[C-1:0]),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

// ===== src/crt_front.sv =====
// Unpacks a word, works out the center offset in doubled units and maps every kind
// onto one test: circle of radius d against a box of half sizes w, h, all in doubled units.
module crt_front #(
    parameter int COORD_BITS = crt_pkg::COORD_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [((8*COORD_BITS-4+7)/8)*8-1:0] s_tdata,
    input  logic [1:0]                  s_tuser,
    output logic                        job_valid,
    input  logic                        job_ready,
    output logic signed [COORD_BITS+1:0] job_ex,
    output logic signed [COORD_BITS+1:0] job_ey,
    output logic [COORD_BITS-1:0]       job_d,
    output logic [COORD_BITS-1:0]       job_w,
    output logic [COORD_BITS-1:0]       job_h
);

    localparam int C   = COORD_BITS;
    localparam int S   = COORD_BITS - 1;
    localparam int RB  = 2*C + 2*S;

    logic [C-1:0] lx, ly, rx, ry;
    logic [S-1:0] lw, lh, rw, rh;
    logic [C-1:0] wsum, hsum;
    logic signed [C+1:0] ex_next, ey_next;
    logic [C-1:0] d_next, w_next, h_next;
    logic valid_reg;
    logic signed [C+1:0] ex_reg, ey_reg;
    logic [C-1:0] d_reg, w_reg, h_reg;
    crt_pkg::kind_t kind;

    assign lx = s_tdata[C-1:0];
    assign ly = s_tdata[2*C-1:C];
    assign lw = s_tdata[2*C+S-1:2*C];
    assign lh = s_tdata[2*C+2*S-1:2*C+S];
    assign rx = s_tdata[RB+C-1:RB];
    assign ry = s_tdata[RB+2*C-1:RB+C];
    assign rw = s_tdata[RB+2*C+S-1:RB+2*C];
    assign rh = s_tdata[RB+2*C+2*S-1:RB+2*C+S];
    assign kind = crt_pkg::kind_t'(s_tuser);

    assign wsum = {1'b0, lw} + {1'b0, rw};
    assign hsum = {1'b0, lh} + {1'b0, rh};

    // offset is symmetric under swap, so always left minus right
    assign ex_next = $signed({lx[C-1], lx, 1'b0}) - $signed({rx[C-1], rx, 1'b0});
    assign ey_next = $signed({ly[C-1], ly, 1'b0}) - $signed({ry[C-1], ry, 1'b0});

    always_comb begin
        unique case (kind)
            crt_pkg::KIND_CIRC_CIRC: begin
                d_next = wsum;
                w_next = '0;
                h_next = '0;
            end
            crt_pkg::KIND_RECT_RECT: begin
                d_next = '0;
                w_next = wsum;
                h_next = hsum;
            end
            crt_pkg::KIND_CIRC_RECT: begin
                d_next = {1'b0, lw};
                w_next = {1'b0, rw};
                h_next = {1'b0, rh};
            end
            default: begin
                d_next = {1'b0, rw};
                w_next = {1'b0, lw};
                h_next = {1'b0, lh};
            end
        endcase
    end

    assign s_tready = !valid_reg || job_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            ex_reg <= ex_next;
            ey_reg <= ey_next;
            d_reg  <= d_next;
            w_reg  <= w_next;
            h_reg  <= h_next;
        end
    end

    assign job_valid = valid_reg;
    assign job_ex    = ex_reg;
    assign job_ey    = ey_reg;
    assign job_d     = d_reg;
    assign job_w     = w_reg;
    assign job_h     = h_reg;

endmodule

// ===== src/crt_fifo.sv =====
module crt_fifo #(
    parameter int DATA_W = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              wr_valid,
    output logic              wr_ready,
    input  logic [DATA_W-1:0] wr_data,
    output logic              rd_valid,
    input  logic              rd_ready,
    output logic [DATA_W-1:0] rd_data
);

    localparam int DEPTH = crt_pkg::QUEUE_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [PW-1:0] wptr_reg, rptr_reg;
    logic [CW-1:0] count_reg;
    logic push, pop;

    assign wr_ready = (count_reg != CW'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;
    assign rd_data  = mem[rptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (push) begin
                wptr_reg <= (wptr_reg == PW'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            end
            if (pop) begin
                rptr_reg <= (rptr_reg == PW'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wptr_reg] <= wr_data;
        end
    end

endmodule

// ===== src/crt_back.sv =====
// Three stages: offsets and limits, box compares and squares, corner sums.
module crt_back #(
    parameter int COORD_BITS = crt_pkg::COORD_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         job_valid,
    output logic                         job_ready,
    input  logic signed [COORD_BITS+1:0] job_ex,
    input  logic signed [COORD_BITS+1:0] job_ey,
    input  logic [COORD_BITS-1:0]        job_d,
    input  logic [COORD_BITS-1:0]        job_w,
    input  logic [COORD_BITS-1:0]        job_h,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [7:0]                   m_tdata
);

    localparam int C  = COORD_BITS;
    localparam int SQ = 2*C + 4;

    logic en1, en2, en_o;
    logic v1_reg, v2_reg, vo_reg;

    // stage 1
    logic signed [C+2:0] ex1_reg, ey1_reg;
    logic signed [C+2:0] px0_reg, px1_reg, py0_reg, py1_reg;
    logic [C:0]          limx_reg, limy_reg;
    logic [C-1:0]        d1_reg, w1_reg, h1_reg;
    logic signed [C+2:0] exw, eyw, ww, hw;

    // stage 2
    logic signed [C+2:0] nex, ney, slx, sly, sw, sh;
    logic                box_next, box_reg;
    logic signed [2*C+5:0] qx0, qx1, qy0, qy1;
    logic [SQ-1:0]       sqx0_reg, sqx1_reg, sqy0_reg, sqy1_reg;
    logic [2*C-1:0]      d2_reg;

    // stage 3
    logic [SQ:0]  s00, s01, s10, s11, dd;
    logic         hit_next, hit_reg;

    assign en_o      = !vo_reg || m_tready;
    assign en2       = !v2_reg || en_o;
    assign en1       = !v1_reg || en2;
    assign job_ready = en1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            vo_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= job_valid;
            if (en2) v2_reg <= v1_reg;
            if (en_o) vo_reg <= v2_reg;
        end
    end

    assign exw = (C+3)'(job_ex);
    assign eyw = (C+3)'(job_ey);
    assign ww  = $signed({3'b000, job_w});
    assign hw  = $signed({3'b000, job_h});

    always_ff @(posedge aclk) begin
        if (en1) begin
            ex1_reg  <= exw;
            ey1_reg  <= eyw;
            px0_reg  <= exw - ww;
            px1_reg  <= exw + ww;
            py0_reg  <= eyw - hw;
            py1_reg  <= eyw + hw;
            limx_reg <= {1'b0, job_w} + {1'b0, job_d};
            limy_reg <= {1'b0, job_h} + {1'b0, job_d};
            d1_reg   <= job_d;
            w1_reg   <= job_w;
            h1_reg   <= job_h;
        end
    end

    assign nex = -ex1_reg;
    assign ney = -ey1_reg;
    assign slx = $signed({2'b00, limx_reg});
    assign sly = $signed({2'b00, limy_reg});
    assign sw  = $signed({3'b000, w1_reg});
    assign sh  = $signed({3'b000, h1_reg});

    // center inside the box grown by d along x, or along y
    assign box_next = (ex1_reg <= slx && nex <= slx && ey1_reg <= sh && ney <= sh) ||
                      (ex1_reg <= sw && nex <= sw && ey1_reg <= sly && ney <= sly);

    assign qx0 = px0_reg * px0_reg;
    assign qx1 = px1_reg * px1_reg;
    assign qy0 = py0_reg * py0_reg;
    assign qy1 = py1_reg * py1_reg;

    always_ff @(posedge aclk) begin
        if (en2) begin
            box_reg  <= box_next;
            sqx0_reg <= qx0[SQ-1:0];
            sqx1_reg <= qx1[SQ-1:0];
            sqy0_reg <= qy0[SQ-1:0];
            sqy1_reg <= qy1[SQ-1:0];
            d2_reg   <= d1_reg * d1_reg;
        end
    end

    assign s00 = {1'b0, sqx0_reg} + {1'b0, sqy0_reg};
    assign s01 = {1'b0, sqx0_reg} + {1'b0, sqy1_reg};
    assign s10 = {1'b0, sqx1_reg} + {1'b0, sqy0_reg};
    assign s11 = {1'b0, sqx1_reg} + {1'b0, sqy1_reg};
    assign dd  = {5'b00000, d2_reg};

    assign hit_next = box_reg || (s00 <= dd) || (s01 <= dd) || (s10 <= dd) || (s11 <= dd);

    always_ff @(posedge aclk) begin
        if (en_o) begin
            hit_reg <= hit_next;
        end
    end

    assign m_tvalid = vo_reg;
    assign m_tdata  = {7'b0000000, hit_reg};

endmodule

// ===== dv/tb_circle_rect_collision_test_unit.sv =====
module tb_circle_rect_collision_test_unit;

    localparam int CB  = crt_pkg::COORD_BITS_DEF;
    localparam int SB  = CB - 1;
    localparam int TDW = ((8*CB-4+7)/8)*8;
    localparam int NUM_RANDOM = 600;

    typedef struct {
        crt_pkg::kind_t       kind;
        logic signed [CB-1:0] lx, ly, rx, ry;
        logic [SB-1:0]        lw, lh, rw, rh;
    } shape_pair_t;

    logic           aclk = 1'b0;
    logic           aresetn = 1'b0;
    logic           s_tvalid = 1'b0;
    logic           s_tready;
    logic [TDW-1:0] s_tdata = '0;
    logic [1:0]     s_tuser = '0;
    logic           m_tvalid;
    logic           m_tready = 1'b0;
    logic [7:0]     m_tdata;

    shape_pair_t pending_pairs[$];
    bit          expected_hits[$];
    int          err_cnt = 0;
    bit          s_fire = 1'b0;
    int          burst_left = 4;
    int          gap_left = 0;
    int          rx_cyc = 0;

    circle_rect_collision_test_unit uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // all geometry is done in doubled units, so half sizes stay exact
    function automatic longint abs64(longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic bit in_radius(longint ex, longint ey, longint r);
        return (ex*ex + ey*ey) <= r*r;
    endfunction

    function automatic bit circle_box_hit(longint cx, longint cy, longint d,
                                          longint bx, longint by,
                                          longint bw, longint bh);
        longint ex, ey, ax, ay;
        int     sx, sy;
        bit     h;
        ex = cx - bx;
        ey = cy - by;
        ax = abs64(ex);
        ay = abs64(ey);
        h = (ax <= bw + d && ay <= bh) || (ax <= bw && ay <= bh + d);
        for (sx = -1; sx <= 1; sx += 2)
            for (sy = -1; sy <= 1; sy += 2)
                h |= in_radius(ex - sx*bw, ey - sy*bh, d);
        return h;
    endfunction

    function automatic bit predict_overlap(shape_pair_t p);
        longint lx = 2 * longint'(p.lx);
        longint ly = 2 * longint'(p.ly);
        longint rx = 2 * longint'(p.rx);
        longint ry = 2 * longint'(p.ry);
        longint lw = longint'(p.lw);
        longint lh = longint'(p.lh);
        longint rw = longint'(p.rw);
        longint rh = longint'(p.rh);
        case (p.kind)
            crt_pkg::KIND_CIRC_CIRC: return in_radius(lx - rx, ly - ry, lw + rw);
            crt_pkg::KIND_RECT_RECT:
                return abs64(lx - rx) <= lw + rw && abs64(ly - ry) <= lh + rh;
            crt_pkg::KIND_CIRC_RECT: return circle_box_hit(lx, ly, lw, rx, ry, rw, rh);
            default:                 return circle_box_hit(rx, ry, rw, lx, ly, lw, lh);
        endcase
    endfunction

    function automatic logic [TDW-1:0] pack_pair(shape_pair_t p);
        return TDW'({p.rh, p.rw, p.ry, p.rx, p.lh, p.lw, p.ly, p.lx});
    endfunction

    function automatic shape_pair_t mk(crt_pkg::kind_t k, int lx, int ly, int lw, int lh,
                                       int rx, int ry, int rw, int rh);
        shape_pair_t p;
        p.kind = k;
        p.lx = lx; p.ly = ly; p.lw = lw; p.lh = lh;
        p.rx = rx; p.ry = ry; p.rw = rw; p.rh = rh;
        return p;
    endfunction

    function automatic shape_pair_t rand_pair();
        shape_pair_t p;
        int sc, ox, oy;
        p.kind = crt_pkg::kind_t'($urandom_range(0, 3));
        p.lx = $urandom; p.ly = $urandom; p.lw = $urandom; p.lh = $urandom;
        p.rx = $urandom; p.ry = $urandom; p.rw = $urandom; p.rh = $urandom;
        // mostly nearby shapes of comparable size, so hits and misses both show up
        if ($urandom_range(0, 3) != 0) begin
            sc = $urandom_range(2, 22);
            ox = int'($urandom_range(0, 1 << (sc+1))) - (1 << sc);
            oy = int'($urandom_range(0, 1 << (sc+1))) - (1 << sc);
            p.rx = p.lx + ox;
            p.ry = p.ly + oy;
            p.lw = $urandom_range(0, 1 << sc);
            p.lh = $urandom_range(0, 1 << sc);
            p.rw = $urandom_range(0, 1 << sc);
            p.rh = $urandom_range(0, 1 << sc);
            if ($urandom_range(0, 15) == 0)
                p.lw = '0;
        end
        return p;
    endfunction

    // driver: hold a word until taken, otherwise bursts with random gaps
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !s_fire) begin
            // word still pending
        end else if (gap_left > 0) begin
            gap_left--;
            s_tvalid <= 1'b0;
        end else if (pending_pairs.size() > 0) begin
            s_tvalid <= 1'b1;
            s_tdata  <= pack_pair(pending_pairs[0]);
            s_tuser  <= pending_pairs[0].kind;
            burst_left--;
            if (burst_left <= 0) begin
                burst_left = $urandom_range(1, 16);
                gap_left   = $urandom_range(0, 1) ? 0 : $urandom_range(1, 6);
            end
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    // receiver stall pattern cycles through several modes
    always @(negedge aclk) begin
        rx_cyc++;
        case ((rx_cyc / 50) % 4)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 3) == 0);
            2: m_tready <= $urandom_range(0, 1);
            default: m_tready <= (rx_cyc % 3 != 0);
        endcase
    end

    // monitor
    always @(posedge aclk) begin
        s_fire = aresetn && s_tvalid && s_tready;
        if (s_fire) begin
            expected_hits.push_back(predict_overlap(pending_pairs[0]));
            void'(pending_pairs.pop_front());
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_hits.size() == 0) begin
                $error("unexpected result word, hit=%0b", m_tdata[0]);
                err_cnt++;
            end else begin
                bit exp_hit;
                exp_hit = expected_hits.pop_front();
                if (m_tdata[0] !== exp_hit) begin
                    $error("hit: expected %0b, got %0b", exp_hit, m_tdata[0]);
                    err_cnt++;
                end
            end
        end
    end

    initial begin
        // point shapes at the same spot touch
        pending_pairs.push_back(mk(crt_pkg::KIND_CIRC_CIRC, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_pairs.push_back(mk(crt_pkg::KIND_RECT_RECT, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_pairs.push_back(mk(crt_pkg::KIND_CIRC_RECT, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_pairs.push_back(mk(crt_pkg::KIND_RECT_CIRC, 0, 0, 0, 0, 0, 0, 0, 0));
        // boxes touching along an edge, then just apart
        pending_pairs.push_back(mk(crt_pkg::KIND_RECT_RECT,
                                   0, 0, 'h100, 'h100, 'h100, 0, 'h100, 'h100));
        pending_pairs.push_back(mk(crt_pkg::KIND_RECT_RECT,
                                   0, 0, 'h100, 'h100, 'h101, 0, 'h100, 'h100));
        // circles touching on a 3-4-5 diagonal, then one lsb short
        pending_pairs.push_back(mk(crt_pkg::KIND_CIRC_CIRC,
                                   0, 0, 'h50, 0, 'h30, 'h40, 'h50, 0));
        pending_pairs.push_back(mk(crt_pkg::KIND_CIRC_CIRC,
                                   0, 0, 'h50, 0, 'h30, 'h40, 'h4f, 0));
        // circle touching a box corner, then one lsb short, both orders
        pending_pairs.push_back(mk(crt_pkg::KIND_CIRC_RECT,
                                   'h130, 'h140, 'ha0, 0, 0, 0, 'h200, 'h200));
        pending_pairs.push_back(mk(crt_pkg::KIND_CIRC_RECT,
                                   'h130, 'h140, 'h9f, 0, 0, 0, 'h200, 'h200));
        pending_pairs.push_back(mk(crt_pkg::KIND_RECT_CIRC,
                                   0, 0, 'h200, 'h200, -'h130, -'h140, 'ha0, 7));
        pending_pairs.push_back(mk(crt_pkg::KIND_RECT_CIRC,
                                   0, 0, 'h200, 'h200, -'h130, -'h140, 'h9f, 7));
        // circle inside the widened box, and inside the heightened box
        pending_pairs.push_back(mk(crt_pkg::KIND_CIRC_RECT,
                                   'h150, 0, 'h100, 0, 0, 0, 'h200, 'h200));
        pending_pairs.push_back(mk(crt_pkg::KIND_RECT_CIRC,
                                   0, 0, 'h200, 'h200, 0, -'h180, 'h100, 0));
        // coordinate and size extremes
        for (int k = 0; k < 4; k++) begin
            pending_pairs.push_back(mk(crt_pkg::kind_t'(k), -8388608, -8388608,
                                       8388607, 8388607,
                                       8388607, 8388607, 8388607, 8388607));
        end
        pending_pairs.push_back(mk(crt_pkg::KIND_RECT_RECT, 8388607, 8388607, 8388607, 8388607,
                                   8388607, 8388607, 8388607, 8388607));
        pending_pairs.push_back(mk(crt_pkg::KIND_CIRC_CIRC, -8388608, -8388608, 0, 0,
                                   -8388608, -8388608, 0, 0));
        pending_pairs.push_back(mk(crt_pkg::KIND_CIRC_RECT, -8388608, 8388607, 8388607, 0,
                                   8388607, -8388608, 8388607, 8388607));
        for (int i = 0; i < NUM_RANDOM; i++)
            pending_pairs.push_back(rand_pair());

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (pending_pairs.size() > 0 || expected_hits.size() > 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);

        if (err_cnt == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== circle_rect_collision_test_unit.f =====
src/crt_pkg.sv
src/crt_front.sv
src/crt_fifo.sv
src/crt_back.sv
src/circle_rect_collision_test_unit.sv
dv/tb_circle_rect_collision_test_unit.sv
